>>> sv/lobm_pkg.sv
package lobm_pkg;

    // Fixed widths: slot index covers the largest book, sum covers 1024 full quantities.
    localparam int IDX_W = 10;
    localparam int SUM_W = 42;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;

    localparam logic [1:0] TYPE_LIMIT  = 2'd0;
    localparam logic [1:0] TYPE_MARKET = 2'd1;
    localparam logic [1:0] TYPE_IOC    = 2'd2;
    localparam logic [1:0] TYPE_FOK    = 2'd3;

    localparam logic [3:0] ST_RESTED    = 4'd0;
    localparam logic [3:0] ST_FILLED    = 4'd1;
    localparam logic [3:0] ST_DROPPED   = 4'd2;
    localparam logic [3:0] ST_KILLED    = 4'd3;
    localparam logic [3:0] ST_DUPLICATE = 4'd4;
    localparam logic [3:0] ST_IGNORED   = 4'd5;
    localparam logic [3:0] ST_CANCELLED = 4'd6;
    localparam logic [3:0] ST_NOT_FOUND = 4'd7;
    localparam logic [3:0] ST_BOOK_FULL = 4'd8;

    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_INSERT = 2'd1;
    localparam logic [1:0] WR_SETQTY = 2'd2;
    localparam logic [1:0] WR_CLEAR  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] order_id;
        logic        side;
        logic [1:0]  order_type;
        logic [31:0] limit_price;
        logic [31:0] order_qty;
    } t_req;

    typedef struct packed {
        logic        is_trade;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [3:0]  status;
        logic        last;
    } t_res;

    // broadcast to every cell during a pass
    typedef struct packed {
        logic        side;
        logic        any_price;
        logic [31:0] limit;
        logic [31:0] id;
        logic [31:0] counter;
    } t_query;

    // slot update, applied by the cell whose index matches
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic             side;
        logic [31:0]      price;
        logic [31:0]      qty;
        logic [31:0]      id;
        logic [31:0]      arrival;
    } t_wr;

    // running result handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best_idx;
        logic [31:0]      best_price;
        logic [31:0]      best_age;
        logic [31:0]      best_qty;
        logic [31:0]      best_id;
        logic             id_hit;
        logic [IDX_W-1:0] id_idx;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
        logic [SUM_W-1:0] sum;
    } t_cand;

endpackage

>>> sv/lobm_cell.sv
module lobm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lobm_pkg::t_query i_query,
    input  lobm_pkg::t_wr   i_wr,
    input  lobm_pkg::t_cand i_cand,
    output lobm_pkg::t_cand o_cand
);
    import lobm_pkg::*;

    logic        r_valid;
    logic        r_side;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic [31:0] r_id;
    logic [31:0] r_arrival;
    t_cand       r_cand;
    t_cand       n_cand;

    logic        w_sel;
    logic        w_ok;
    logic        w_better;
    logic [31:0] w_age;

    assign w_sel = (i_wr.idx == IDX_W'(CELL_IDX)) && (i_wr.op != WR_NONE);
    assign w_age = i_query.counter - r_arrival;

    always_comb begin
        w_ok = r_valid && (r_side != i_query.side) &&
               (i_query.any_price ||
                (i_query.side == 1'b0 ? (r_price <= i_query.limit)
                                      : (r_price >= i_query.limit)));
        if (!i_cand.found) begin
            w_better = 1'b1;
        end else if (r_price != i_cand.best_price) begin
            w_better = (i_query.side == 1'b0) ? (r_price < i_cand.best_price)
                                              : (r_price > i_cand.best_price);
        end else begin
            w_better = w_age > i_cand.best_age;
        end

        n_cand = i_cand;
        if (w_ok) begin
            n_cand.sum = i_cand.sum + SUM_W'(r_qty);
            if (w_better) begin
                n_cand.found      = 1'b1;
                n_cand.best_idx   = IDX_W'(CELL_IDX);
                n_cand.best_price = r_price;
                n_cand.best_age   = w_age;
                n_cand.best_qty   = r_qty;
                n_cand.best_id    = r_id;
            end
        end
        if (!i_cand.id_hit && r_valid && r_id == i_query.id) begin
            n_cand.id_hit = 1'b1;
            n_cand.id_idx = IDX_W'(CELL_IDX);
        end
        if (!i_cand.free_hit && !r_valid) begin
            n_cand.free_hit = 1'b1;
            n_cand.free_idx = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            case (i_wr.op)
                WR_INSERT: r_valid <= 1'b1;
                WR_SETQTY: r_valid <= (i_wr.qty != 32'd0);
                WR_CLEAR:  r_valid <= 1'b0;
                default:   r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.op == WR_INSERT) begin
            r_side    <= i_wr.side;
            r_price   <= i_wr.price;
            r_id      <= i_wr.id;
            r_arrival <= i_wr.arrival;
        end
        if (w_sel && (i_wr.op == WR_INSERT || i_wr.op == WR_SETQTY)) begin
            r_qty <= i_wr.qty;
        end
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

endmodule

>>> sv/limit_order_book_matcher_unit.sv
// Price-time priority order book of MAX_ORDERS slots held in a chain of cells.
// Every search is one pass of a candidate down the chain, one cell per cycle,
// then an evaluate step. An item takes one lookup pass (id and fill-or-kill
// depth), then one best-price pass per trade plus, if quantity is left, one
// more pass that finds no match, and a further free-slot pass when a limit
// remainder rests; cancels and rejects end after the lookup pass. busy is high
// from transfer until the final result is shown. Results are strobed on
// o_res_stb for one cycle each and cannot be held off: the receiver must take
// every one; last marks the status record.
module limit_order_book_matcher_unit #(
    parameter int MAX_ORDERS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lobm_pkg::t_req i_req,
    output logic           o_res_stb,
    output lobm_pkg::t_res o_res
);
    import lobm_pkg::*;

    localparam int CW = (MAX_ORDERS > 2) ? $clog2(MAX_ORDERS) : 1;
    localparam int GW = $clog2(MAX_ORDERS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    localparam logic [1:0] P_LOOK = 2'd0;
    localparam logic [1:0] P_BEST = 2'd1;
    localparam logic [1:0] P_FREE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_pass, n_pass;
    t_req          r_req, n_req;
    logic [31:0]   r_qty, n_qty;
    logic [31:0]   r_ctr, n_ctr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [GW-1:0] r_guard, n_guard;
    logic          r_nomatch, n_nomatch;
    t_wr           r_wr, n_wr;
    t_res          r_res, n_res;
    logic          r_stb, n_stb;

    t_query        w_query;
    t_cand         w_cand [MAX_ORDERS+1];
    t_cand         w_end;
    logic          w_any;
    logic          w_rest;
    logic [31:0]   w_tq;

    assign w_any  = (r_req.order_type == TYPE_MARKET) || (r_req.limit_price == 32'd0);
    assign w_rest = (r_req.order_type == TYPE_LIMIT) && !w_any;

    assign w_query.side      = r_req.side;
    assign w_query.any_price = (r_pass == P_LOOK) ? (r_req.limit_price == 32'd0) : w_any;
    assign w_query.limit     = r_req.limit_price;
    assign w_query.id        = r_req.order_id;
    assign w_query.counter   = r_ctr;

    assign w_cand[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_ORDERS; g++) begin : g_cell
            lobm_cell #(.CELL_IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_query (w_query),
                .i_wr    (r_wr),
                .i_cand  (w_cand[g]),
                .o_cand  (w_cand[g+1])
            );
        end
    endgenerate

    assign w_end = w_cand[MAX_ORDERS];
    assign w_tq  = (r_qty < w_end.best_qty) ? r_qty : w_end.best_qty;

    always_comb begin
        n_state   = r_state;
        n_pass    = r_pass;
        n_req     = r_req;
        n_qty     = r_qty;
        n_ctr     = r_ctr;
        n_cnt     = r_cnt;
        n_guard   = r_guard;
        n_nomatch = r_nomatch;
        n_wr      = r_wr;
        n_wr.op   = WR_NONE;
        n_res     = '0;
        n_stb     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_pass  = P_LOOK;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(MAX_ORDERS - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                case (r_pass)
                    P_LOOK: begin
                        n_stb      = 1'b1;
                        n_res.last = 1'b1;
                        if (r_req.kind == KIND_CANCEL) begin
                            n_res.status = w_end.id_hit ? ST_CANCELLED : ST_NOT_FOUND;
                            if (w_end.id_hit) begin
                                n_wr.op  = WR_CLEAR;
                                n_wr.idx = w_end.id_idx;
                            end
                        end else if (r_req.order_qty == 32'd0) begin
                            n_res.status = ST_IGNORED;
                        end else if (w_end.id_hit) begin
                            n_res.status = ST_DUPLICATE;
                        end else begin
                            n_ctr = r_ctr + 32'd1;
                            if (r_req.order_type == TYPE_FOK &&
                                w_end.sum < SUM_W'(r_req.order_qty)) begin
                                n_res.status = ST_KILLED;
                            end else begin
                                n_stb      = 1'b0;
                                n_res      = '0;
                                n_qty      = r_req.order_qty;
                                n_guard    = '0;
                                n_nomatch  = 1'b0;
                                n_state    = S_POST;
                            end
                        end
                    end
                    P_BEST: begin
                        n_state = S_POST;
                        if (w_end.found) begin
                            n_stb             = 1'b1;
                            n_res.is_trade    = 1'b1;
                            n_res.buyer_id    = (r_req.side == 1'b0) ? r_req.order_id
                                                                      : w_end.best_id;
                            n_res.seller_id   = (r_req.side == 1'b0) ? w_end.best_id
                                                                      : r_req.order_id;
                            n_res.trade_price = w_end.best_price;
                            n_res.trade_qty   = w_tq;
                            n_wr.op           = WR_SETQTY;
                            n_wr.idx          = w_end.best_idx;
                            n_wr.qty          = w_end.best_qty - w_tq;
                            n_qty             = r_qty - w_tq;
                            n_guard           = r_guard + 1'b1;
                        end else begin
                            n_nomatch = 1'b1;
                        end
                    end
                    default: begin
                        n_stb      = 1'b1;
                        n_res.last = 1'b1;
                        if (w_end.free_hit) begin
                            n_res.status = ST_RESTED;
                            n_wr.op      = WR_INSERT;
                            n_wr.idx     = w_end.free_idx;
                            n_wr.side    = r_req.side;
                            n_wr.price   = r_req.limit_price;
                            n_wr.qty     = r_qty;
                            n_wr.id      = r_req.order_id;
                            n_wr.arrival = r_ctr;
                        end else begin
                            n_res.status = ST_BOOK_FULL;
                        end
                    end
                endcase
            end
            default: begin
                // S_POST: next trade, free-slot search or final status
                if (r_qty != 32'd0 && r_guard < GW'(MAX_ORDERS) && !r_nomatch) begin
                    n_pass  = P_BEST;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else if (r_qty != 32'd0 && w_rest) begin
                    n_pass  = P_FREE;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_stb        = 1'b1;
                    n_res.last   = 1'b1;
                    n_res.status = (r_qty == 32'd0) ? ST_FILLED : ST_DROPPED;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctr   <= '0;
            r_guard <= '0;
            r_stb   <= 1'b0;
            r_wr.op <= WR_NONE;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_guard <= n_guard;
            r_stb   <= n_stb;
            r_wr.op <= n_wr.op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass       <= n_pass;
        r_req        <= n_req;
        r_qty        <= n_qty;
        r_cnt        <= n_cnt;
        r_nomatch    <= n_nomatch;
        r_wr.idx     <= n_wr.idx;
        r_wr.side    <= n_wr.side;
        r_wr.price   <= n_wr.price;
        r_wr.qty     <= n_wr.qty;
        r_wr.id      <= n_wr.id;
        r_wr.arrival <= n_wr.arrival;
        r_res        <= n_res;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_res_stb = r_stb;
    assign o_res     = r_res;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer did not raise busy");
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && o_res.last |-> !o_res.is_trade)
        else $error("final record is a trade");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && o_res.is_trade |-> busy)
        else $error("trade shown after item finished");
    a_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= GW'(MAX_ORDERS) || r_state == S_IDLE)
        else $error("trade count exceeds book size");
`endif

endmodule
